[hw/rtl/swap_slot_bitmap_allocator_defines.svh]
// Assertion macros for the swap slot bitmap allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SWAP_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`define SWAP_SLOT_BITMAP_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SSBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error(msg);
`define SSBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSBA_ASSERT(lbl, clk, rstn, prop, msg)
`define SSBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/ssba_pkg.sv]
// Shared types and constants of the swap slot bitmap allocator.
// No dependencies; imported by the bitmap store and the top level.
package ssba_pkg;

  localparam int WORD_W               = 32;
  localparam int WORD_SHIFT           = 5;
  localparam int SLOT_COUNT_DEF       = 1024;
  localparam int SECTORS_PER_SLOT_DEF = 8;

  localparam int CFG_W    = 11;
  localparam int IDX_W    = 10;
  localparam int SECTOR_W = 13;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 11'd1024;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_USED = 2'd2
  } status_e;

  typedef struct packed {
    op_e              opcode;
    logic [IDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [IDX_W-1:0]    slot;
    logic [SECTOR_W-1:0] sector_address;
    logic                last;
  } rsp_t;

endpackage

[hw/rtl/ssba_bitmap.sv]
// Word-wide used-slot bitmap: one synchronous RAM with a registered read.
// Sweeps every word to zero after reset. Depends on ssba_pkg.
module ssba_bitmap #(
  parameter int NUM_WORDS = 32,
  parameter int AW        = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [AW-1:0]               rd_addr_i,
  output logic [ssba_pkg::WORD_W-1:0] rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AW-1:0]               wr_addr_i,
  input  logic [ssba_pkg::WORD_W-1:0] wr_data_i,
  output logic                        ready_o
);
  import ssba_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [WORD_W-1:0] rd_data_q;
  logic [AW-1:0]     clr_ptr_q, clr_ptr_d;
  logic              clr_busy_q, clr_busy_d;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  always_comb begin
    clr_ptr_d  = clr_ptr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_ptr_d = clr_ptr_q + AW'(1);
      if (clr_ptr_q == AW'(NUM_WORDS - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  // clearing pass owns the write port until it is done
  assign we    = clr_busy_q | wr_en_i;
  assign waddr = clr_busy_q ? clr_ptr_q : wr_addr_i;
  assign wdata = clr_busy_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_ptr_q  <= clr_ptr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clr_busy_q;

endmodule

[hw/rtl/swap_slot_bitmap_allocator.sv]
// First-fit swap slot allocator over a word-wide bitmap RAM (32 slots a word).
// An allocation reads the bitmap word at the search hint; when it holds a free slot, the word
// is written back with that slot set and results follow, else the next word is read. No new
// request is taken until the last result is out; results run one a cycle while
// out_stall_i is low. Reset: a clearing pass writes every bitmap word with input stalled;
// slots_in_use resets to 1024. Depends on ssba_pkg and ssba_bitmap.
`include "swap_slot_bitmap_allocator_defines.svh"
module swap_slot_bitmap_allocator #(
  parameter int SLOT_COUNT       = ssba_pkg::SLOT_COUNT_DEF,
  parameter int SECTORS_PER_SLOT = ssba_pkg::SECTORS_PER_SLOT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ssba_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ssba_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output ssba_pkg::rsp_t             out_rsp_o
);
  import ssba_pkg::*;

  localparam int NUM_WORDS = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int HW        = AW + 1;
  localparam int SLOT_W    = $clog2(SLOT_COUNT);
  localparam int SW        = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
  localparam int CW        = (HW + WORD_SHIFT > 12) ? HW + WORD_SHIFT : 12;
  localparam int CNT_W     = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ARD  = 3'd1;
  localparam logic [2:0] S_FRD  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;

  logic [2:0]         state_q, state_d;
  logic [CFG_W-1:0]   cfg_q;
  logic [HW-1:0]      hint_q, hint_d;
  logic [HW-1:0]      ptr_q, ptr_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [SW-1:0]      slot_q, slot_d;
  status_e            status_q, status_d;
  logic               err_q, err_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  rsp_t               out_q, out_d;

  logic               map_ready;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [WORD_W-1:0]  rd_data, wr_data;

  logic               in_acc;
  logic [CW-1:0]      limit, base, base_next, rem;
  logic [HW-1:0]      ptr_next;
  logic [WORD_W-1:0]  mask, free_bits, bit_sel;
  logic [WORD_SHIFT-1:0] low_bit;
  logic               load_out, last_res;

  function automatic logic [WORD_SHIFT-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [WORD_SHIFT-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = WORD_SHIFT'(i);
      end
    end
    return r;
  endfunction

  ssba_bitmap #(
    .NUM_WORDS(NUM_WORDS),
    .AW       (AW)
  ) u_bitmap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .ready_o  (map_ready)
  );

  assign in_stall_o = (state_q != S_IDLE) || !map_ready;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign limit     = (CW'(cfg_q) > CW'(SLOT_COUNT)) ? CW'(SLOT_COUNT) : CW'(cfg_q);
  assign base      = CW'({ptr_q, {WORD_SHIFT{1'b0}}});
  assign ptr_next  = ptr_q + HW'(1);
  assign base_next = CW'({ptr_next, {WORD_SHIFT{1'b0}}});
  assign rem       = limit - base;
  // only slots below the usable count take part in the search
  assign mask      = (rem >= CW'(WORD_W)) ? '1
                   : ((WORD_W'(1) << rem[WORD_SHIFT-1:0]) - WORD_W'(1));
  assign free_bits = ~rd_data & mask;
  assign low_bit   = lowest_set(free_bits);

  always_comb begin
    bit_sel = '0;
    unique case (state_q)
      S_ARD:   bit_sel = WORD_W'(1) << low_bit;
      S_FRD:   bit_sel = WORD_W'(1) << idx_q[WORD_SHIFT-1:0];
      default: bit_sel = '0;
    endcase
  end

  assign last_res = err_q || (cnt_q == CNT_W'(SECTORS_PER_SLOT - 1));
  assign load_out = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d  = state_q;
    hint_d   = hint_q;
    ptr_d    = ptr_q;
    idx_d    = idx_q;
    slot_d   = slot_q;
    status_d = status_q;
    err_d    = err_q;
    cnt_d    = cnt_q;
    rd_en    = 1'b0;
    rd_addr  = ptr_q[AW-1:0];
    wr_en    = 1'b0;
    wr_addr  = ptr_q[AW-1:0];
    wr_data  = rd_data;
    out_d    = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          idx_d = in_req_i.slot_index;
          cnt_d = '0;
          if (in_req_i.opcode == OP_ALLOC) begin
            if (CW'({hint_q, {WORD_SHIFT{1'b0}}}) >= limit) begin
              status_d = ST_FULL;
              err_d    = 1'b1;
              slot_d   = '0;
              state_d  = S_EMIT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = hint_q[AW-1:0];
              ptr_d   = hint_q;
              state_d = S_ARD;
            end
          end else begin
            if (CW'(in_req_i.slot_index) >= CW'(SLOT_COUNT)) begin
              status_d = ST_NOT_USED;
              err_d    = 1'b1;
              slot_d   = SW'(in_req_i.slot_index);
              state_d  = S_EMIT;
            end else begin
              rd_en   = 1'b1;
              rd_addr = AW'(in_req_i.slot_index >> WORD_SHIFT);
              ptr_d   = HW'(in_req_i.slot_index >> WORD_SHIFT);
              state_d = S_FRD;
            end
          end
        end
      end

      S_ARD: begin
        if (|free_bits) begin
          wr_en    = 1'b1;
          wr_data  = rd_data | bit_sel;
          if (ptr_q == hint_q && (&(rd_data | bit_sel))) begin
            hint_d = hint_q + HW'(1);
          end
          slot_d   = SW'({ptr_q, low_bit});
          status_d = ST_OK;
          err_d    = 1'b0;
          state_d  = S_EMIT;
        end else begin
          // skip past a full word at the head of the scan
          if (ptr_q == hint_q && (&rd_data)) begin
            hint_d = hint_q + HW'(1);
          end
          if (base_next >= limit) begin
            status_d = ST_FULL;
            err_d    = 1'b1;
            slot_d   = '0;
            state_d  = S_EMIT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_next[AW-1:0];
            ptr_d   = ptr_next;
          end
        end
      end

      S_FRD: begin
        if (!rd_data[idx_q[WORD_SHIFT-1:0]]) begin
          status_d = ST_NOT_USED;
          err_d    = 1'b1;
        end else begin
          wr_en    = 1'b1;
          wr_data  = rd_data & ~bit_sel;
          if (ptr_q < hint_q) begin
            hint_d = ptr_q;
          end
          status_d = ST_OK;
          err_d    = 1'b0;
        end
        slot_d  = SW'(idx_q);
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (load_out) begin
          out_d.status         = status_q;
          out_d.slot           = slot_q[IDX_W-1:0];
          out_d.sector_address = err_q ? '0
                               : SECTOR_W'(slot_q * SECTORS_PER_SLOT + int'(cnt_q));
          out_d.last           = last_res;
          if (last_res) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= SLOTS_IN_USE_RST;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    err_q    <= err_d;
    cnt_q    <= cnt_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SSBA_ASSERT(a_hint_range, clk_i, rst_ni, hint_q <= HW'(NUM_WORDS), "search hint past map end")
  `SSBA_ASSERT(a_err_form, clk_i, rst_ni, out_valid_o && out_rsp_o.status != ST_OK |-> out_rsp_o.last && out_rsp_o.sector_address == '0, "error item not a single zero-sector item")
  `SSBA_ASSERT(a_busy_after_acc, clk_i, rst_ni, in_acc |=> in_stall_o, "accepted a second item while busy")
  `SSBA_ASSERT(a_wr_in_rmw, clk_i, rst_ni, wr_en |-> state_q == S_ARD || state_q == S_FRD, "bitmap write outside read-modify-write")

endmodule
